/* rtl/core/tblmc_pkg.sv */
// Package for the two-button light mode controller: mode codes, register
// indexes, reset values and the saturating ramp helper.
// Depends on nothing; the top level uses it.
package tblmc_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] calib_t;
  typedef logic [1:0] reg_idx_t;

  localparam mode_t MODE_LAMP = 2'd0;
  localparam mode_t MODE_PLAY = 2'd1;
  localparam mode_t MODE_BEAM = 2'd2;
  localparam mode_t MODE_DARK = 2'd3;

  localparam calib_t CALIB_BRIGHT = 2'd0;
  localparam calib_t CALIB_HUE    = 2'd1;
  localparam calib_t CALIB_SAT    = 2'd2;

  // Register indexes (byte address is four times the index).
  localparam reg_idx_t REG_MAX_BRIGHT  = 2'd0;
  localparam reg_idx_t REG_LONGPRESS   = 2'd1;
  localparam reg_idx_t REG_DEMO_TIMEOUT = 2'd2;

  localparam int CFG_ADDR_W = 4;

  // Number of playground patterns, from 1 to 8.
  localparam logic [3:0] PATTERN_COUNT = 4'd5;

  localparam logic [7:0]  RST_MAX_BRIGHT  = 8'd255;
  localparam logic [15:0] RST_LONGPRESS   = 16'd3000;
  localparam logic [31:0] RST_DEMO_TIMEOUT = 32'd3600000;
  localparam logic [7:0]  RST_HUE         = 8'd50;
  localparam logic [7:0]  RST_SAT         = 8'd128;
  localparam logic [7:0]  RST_BRIGHT      = 8'd128;

  // One step up or down, held at the ends of the range.
  function automatic logic [7:0] ramp(input logic [7:0] v, input logic down);
    logic [7:0] r;
    if (down) begin
      r = (v != 8'd0) ? v - 8'd1 : 8'd0;
    end else begin
      r = (v != 8'd255) ? v + 8'd1 : 8'd255;
    end
    return r;
  endfunction

endpackage

/* rtl/core/tblmc_if.sv */
// Handshake interfaces for the tick channel and the result channel.
// Depends on nothing but the valid/ready convention of the block.
interface tblmc_tick_if;
  logic        valid;
  logic        ready;
  logic        mode_button;
  logic        action_button;
  logic [31:0] now_ms;

  modport source (output valid, mode_button, action_button, now_ms, input ready);
  modport sink   (input valid, mode_button, action_button, now_ms, output ready);
endinterface

interface tblmc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] calib_step;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] scaled_brightness;
  logic [2:0] pattern_index;
  logic [7:0] strip_gain;
  logic       redraw;
  logic       feedback_cycle;

  modport source (output valid, mode, calib_step, hue, saturation, scaled_brightness,
                  pattern_index, strip_gain, redraw, feedback_cycle, input ready);
  modport sink   (input valid, mode, calib_step, hue, saturation, scaled_brightness,
                  pattern_index, strip_gain, redraw, feedback_cycle, output ready);
endinterface

/* rtl/core/two_button_light_mode_controller.sv */
// Top level of the two-button light mode controller: button handling, demo
// timeout, brightness scaling, result register and configuration registers.
// Depends on tblmc_pkg and the interfaces in tblmc_if.sv.
//
//   Channel   | Direction | Handshake            | Carries
//   ----------+-----------+----------------------+----------------------------------
//   in_tick   | in        | valid/ready          | button levels and millisecond time
//   out_res   | out       | valid/ready          | mode, settings, gain, flags
//   APB port  | in        | psel/penable, pready | max brightness, long press, timeout
//
// Every tick transaction is handled in the cycle it is accepted: the state
// and the result register are written at that same edge, so the result is
// presented in the next cycle, and a new tick can be accepted every cycle while the sink takes each result.
// in_tick.ready is low only while reset is asserted or while a result is
// held in the output register that the sink is not taking this cycle.
// Reset is synchronous and active low; it restores every setting and the
// configuration registers to their defaults. pready is always high.
module two_button_light_mode_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tblmc_tick_if.sink                           in_tick,
  tblmc_res_if.source                          out_res,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tblmc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  // Configuration registers.
  logic [7:0]  max_bright_r;
  logic [15:0] longpress_r;
  logic [31:0] demo_timeout_r;

  // Controller state.
  tblmc_pkg::mode_t  mode_r, mode_nxt;
  tblmc_pkg::calib_t calib_r, calib_nxt;
  logic        mode_held_r, mode_held_nxt;
  logic        long_active_r, long_active_nxt;
  logic [31:0] long_deadline_r, long_deadline_nxt;
  logic [7:0]  hue_r, hue_nxt;
  logic [7:0]  sat_r, sat_nxt;
  logic [7:0]  bright_r, bright_nxt;
  logic [7:0]  last_bright_r, last_bright_nxt;
  logic        bright_down_r, bright_down_nxt;
  logic        sat_down_r, sat_down_nxt;
  logic        action_held_r, action_held_nxt;
  logic [2:0]  pattern_r, pattern_nxt;
  logic [31:0] mode_deadline_r, mode_deadline_nxt;
  logic [7:0]  gain_r, gain_nxt;

  // Result register.
  logic        out_valid_r;
  tblmc_pkg::mode_t  out_mode_r;
  tblmc_pkg::calib_t out_calib_r;
  logic [7:0]  out_hue_r, out_sat_r, out_scaled_r, out_gain_r;
  logic [2:0]  out_pattern_r;
  logic        out_redraw_r, out_feedback_r;

  // Per-tick combinational results.
  logic        feedback, redraw, demo_enter, long_due, demo_due;
  logic [3:0]  pattern_inc;
  logic [32:0] long_sum, demo_sum;
  logic [15:0] bright_prod;
  logic [16:0] div_sum;
  logic [7:0]  scaled;
  logic        in_accept, cfg_wr;
  tblmc_pkg::reg_idx_t cfg_idx;

  assign in_tick.ready = rst_n && (!out_valid_r || out_res.ready);
  assign in_accept     = in_tick.valid && in_tick.ready;

  // Both deadlines are sums of the current time and a register. A compare of
  // "now > now + x" is simply the carry out of that sum, so a deadline that
  // wraps past the top of the time range fires at once.
  assign long_sum = {1'b0, in_tick.now_ms} + {17'd0, longpress_r};
  assign demo_sum = {1'b0, in_tick.now_ms} + {1'b0, demo_timeout_r};

  assign pattern_inc = {1'b0, pattern_r} + 4'd1;

  always_comb begin
    mode_nxt          = mode_r;
    calib_nxt         = calib_r;
    mode_held_nxt     = mode_held_r;
    long_active_nxt   = long_active_r;
    long_deadline_nxt = long_deadline_r;
    hue_nxt           = hue_r;
    sat_nxt           = sat_r;
    bright_nxt        = bright_r;
    last_bright_nxt   = last_bright_r;
    bright_down_nxt   = bright_down_r;
    sat_down_nxt      = sat_down_r;
    action_held_nxt   = action_held_r;
    pattern_nxt       = pattern_r;
    mode_deadline_nxt = mode_deadline_r;
    gain_nxt          = gain_r;
    feedback          = 1'b0;
    redraw            = 1'b0;
    demo_enter        = 1'b0;

    // Mode button. On the first tick of a press the deadline is being set
    // now, so the long-press test uses the fresh sum's carry.
    long_due = mode_held_r ? (in_tick.now_ms > long_deadline_r) : long_sum[32];
    if (in_tick.mode_button) begin
      if (!mode_held_r) begin
        long_deadline_nxt = long_sum[31:0];
      end
      mode_held_nxt = 1'b1;
      if (!long_active_r && long_due) begin
        long_active_nxt = 1'b1;
        if (mode_r == tblmc_pkg::MODE_LAMP) begin
          calib_nxt = tblmc_pkg::CALIB_HUE;
          feedback  = 1'b1;
        end
      end
    end else begin
      if (mode_held_r) begin
        if (long_active_r) begin
          long_active_nxt = 1'b0;
        end else if (calib_r != tblmc_pkg::CALIB_BRIGHT) begin
          // Hue goes to saturation, saturation back to brightness; the
          // unused fourth code goes to hue.
          case (calib_r)
            tblmc_pkg::CALIB_HUE: calib_nxt = tblmc_pkg::CALIB_SAT;
            tblmc_pkg::CALIB_SAT: calib_nxt = tblmc_pkg::CALIB_BRIGHT;
            default:              calib_nxt = tblmc_pkg::CALIB_HUE;
          endcase
          feedback        = 1'b1;
          last_bright_nxt = 8'd0;
        end else begin
          mode_nxt = mode_r + 2'd1;
          case (mode_nxt)
            tblmc_pkg::MODE_LAMP: begin
              mode_deadline_nxt = 32'd0;
              last_bright_nxt   = 8'd0;
              gain_nxt          = max_bright_r;
            end
            tblmc_pkg::MODE_DARK: begin
              mode_deadline_nxt = 32'd0;
              gain_nxt          = 8'd0;
            end
            default: begin
              mode_deadline_nxt = demo_sum[31:0];
              gain_nxt          = max_bright_r;
              demo_enter        = 1'b1;
            end
          endcase
        end
      end
      mode_held_nxt = 1'b0;
    end

    // Action button, acting on the mode and step just settled above.
    if (in_tick.action_button) begin
      if (mode_nxt == tblmc_pkg::MODE_LAMP) begin
        if (calib_nxt == tblmc_pkg::CALIB_HUE) begin
          hue_nxt = hue_r + 8'd1;
        end else if (calib_nxt == tblmc_pkg::CALIB_SAT) begin
          sat_nxt = tblmc_pkg::ramp(sat_r, sat_down_r);
        end else begin
          bright_nxt = tblmc_pkg::ramp(bright_r, bright_down_r);
        end
      end else if (mode_nxt == tblmc_pkg::MODE_PLAY) begin
        // Playground: one pattern step on the press edge only.
        if (!action_held_r) begin
          pattern_nxt = (pattern_inc >= tblmc_pkg::PATTERN_COUNT) ? 3'd0 : pattern_inc[2:0];
        end
      end
      action_held_nxt = 1'b1;
    end else begin
      if (action_held_r && mode_nxt == tblmc_pkg::MODE_LAMP) begin
        if (calib_nxt == tblmc_pkg::CALIB_BRIGHT) begin
          bright_down_nxt = !bright_down_r;
        end else if (calib_nxt == tblmc_pkg::CALIB_SAT) begin
          sat_down_nxt = !sat_down_r;
        end
      end
      action_held_nxt = 1'b0;
    end

    // Demo timeout. A zero deadline means no timeout is armed; a step into
    // light or off on this tick has already cleared it.
    demo_due = demo_enter ? (demo_sum[32] && (demo_sum[31:0] != 32'd0))
                          : ((mode_deadline_nxt != 32'd0) &&
                             (in_tick.now_ms > mode_deadline_nxt));
    if (demo_due) begin
      mode_nxt          = tblmc_pkg::MODE_LAMP;
      mode_deadline_nxt = 32'd0;
      last_bright_nxt   = 8'd0;
      gain_nxt          = max_bright_r;
    end

    // Light render: refill when brightness moved or while calibrating.
    if (mode_nxt == tblmc_pkg::MODE_LAMP) begin
      if (last_bright_nxt != bright_nxt || calib_nxt != tblmc_pkg::CALIB_BRIGHT) begin
        redraw          = 1'b1;
        last_bright_nxt = bright_nxt;
      end
    end
  end

  // Exact floor of p / 255 for any product p of two 8-bit values: (p + (p >> 8) + 1) >> 8.
  assign bright_prod = {8'd0, bright_nxt} * {8'd0, max_bright_r};
  assign div_sum     = {1'b0, bright_prod} + {9'd0, bright_prod[15:8]} + 17'd1;
  assign scaled      = div_sum[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= tblmc_pkg::MODE_LAMP;
      calib_r         <= tblmc_pkg::CALIB_BRIGHT;
      mode_held_r     <= 1'b0;
      long_active_r   <= 1'b0;
      long_deadline_r <= 32'd0;
      hue_r           <= tblmc_pkg::RST_HUE;
      sat_r           <= tblmc_pkg::RST_SAT;
      bright_r        <= tblmc_pkg::RST_BRIGHT;
      last_bright_r   <= 8'd0;
      bright_down_r   <= 1'b0;
      sat_down_r      <= 1'b0;
      action_held_r   <= 1'b0;
      pattern_r       <= 3'd0;
      mode_deadline_r <= 32'd0;
      gain_r          <= tblmc_pkg::RST_MAX_BRIGHT;
    end else if (in_accept) begin
      mode_r          <= mode_nxt;
      calib_r         <= calib_nxt;
      mode_held_r     <= mode_held_nxt;
      long_active_r   <= long_active_nxt;
      long_deadline_r <= long_deadline_nxt;
      hue_r           <= hue_nxt;
      sat_r           <= sat_nxt;
      bright_r        <= bright_nxt;
      last_bright_r   <= last_bright_nxt;
      bright_down_r   <= bright_down_nxt;
      sat_down_r      <= sat_down_nxt;
      action_held_r   <= action_held_nxt;
      pattern_r       <= pattern_nxt;
      mode_deadline_r <= mode_deadline_nxt;
      gain_r          <= gain_nxt;
    end
  end

  // Result register: loaded on every accepted transaction, emptied when the
  // sink takes it without a new one arriving.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_mode_r     <= mode_nxt;
      out_calib_r    <= calib_nxt;
      out_hue_r      <= hue_nxt;
      out_sat_r      <= sat_nxt;
      out_scaled_r   <= scaled;
      out_pattern_r  <= pattern_nxt;
      out_gain_r     <= gain_nxt;
      out_redraw_r   <= redraw;
      out_feedback_r <= feedback;
    end
  end

  assign out_res.valid             = out_valid_r;
  assign out_res.mode              = out_mode_r;
  assign out_res.calib_step        = out_calib_r;
  assign out_res.hue               = out_hue_r;
  assign out_res.saturation        = out_sat_r;
  assign out_res.scaled_brightness = out_scaled_r;
  assign out_res.pattern_index     = out_pattern_r;
  assign out_res.strip_gain        = out_gain_r;
  assign out_res.redraw            = out_redraw_r;
  assign out_res.feedback_cycle    = out_feedback_r;

  // Configuration port. Registers sit at four-byte steps, decoded from paddr[3:2]
  // only; index three is ignored on write and reads as zero.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bright_r   <= tblmc_pkg::RST_MAX_BRIGHT;
      longpress_r    <= tblmc_pkg::RST_LONGPRESS;
      demo_timeout_r <= tblmc_pkg::RST_DEMO_TIMEOUT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tblmc_pkg::REG_MAX_BRIGHT:   max_bright_r   <= pwdata[7:0];
        tblmc_pkg::REG_LONGPRESS:    longpress_r    <= pwdata[15:0];
        tblmc_pkg::REG_DEMO_TIMEOUT: demo_timeout_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tblmc_pkg::REG_MAX_BRIGHT:   prdata = {24'd0, max_bright_r};
      tblmc_pkg::REG_LONGPRESS:    prdata = {16'd0, longpress_r};
      tblmc_pkg::REG_DEMO_TIMEOUT: prdata = demo_timeout_r;
      default:                     prdata = 32'd0;
    endcase
  end

  // Assertions.
  a_redraw_light: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_redraw_r) |-> (out_mode_r == tblmc_pkg::MODE_LAMP))
    else $error("redraw flagged outside light mode");

  a_off_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
      (mode_r == tblmc_pkg::MODE_DARK) |-> (gain_r == 8'd0))
    else $error("strip gain nonzero in off mode");

  a_calib_light: assert property (@(posedge clk) disable iff (!rst_n)
      (calib_r != tblmc_pkg::CALIB_BRIGHT) |-> (mode_r == tblmc_pkg::MODE_LAMP))
    else $error("calibration active outside light mode");

  a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
      ({1'b0, pattern_r} < tblmc_pkg::PATTERN_COUNT))
    else $error("pattern selector out of range");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
      in_accept |=> out_valid_r)
    else $error("accepted tick produced no result");

endmodule
